### rtl/core/imu_pkg.sv
// ----------------------------------------------------------------------------
// imu_pkg
// Shared word width, derived sizes and operation codes for the iterative
// integer math unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_pkg;

   // operand and result word width
   localparam int DATA_WIDTH = 32;

   // divide step counter width, one step per quotient bit
   localparam int STEP_W = $clog2(DATA_WIDTH);

   // highest even bit index below the sign bit, first square root trial bit
   localparam int SQRT_TOP = ((DATA_WIDTH - 2) / 2) * 2;

   // operation codes carried on the kind port
   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_SUB    = 3'd1,
      KIND_MUL    = 3'd2,
      KIND_DIV    = 3'd3,
      KIND_SELECT = 3'd4,
      KIND_SQRT   = 3'd5,
      KIND_POWER  = 3'd6
   } kind_type;

endpackage : imu_pkg

`default_nettype wire

### rtl/core/iterative_integer_math_unit.sv
// ----------------------------------------------------------------------------
// iterative_integer_math_unit
// Add, sub, select and rejected operands are answered straight from idle;
// divide takes one restoring step per quotient bit, then a sign fix; square
// root takes one bit pair per cycle; multiply is one accumulate step, and
// power is one accumulate step per set exponent bit and one squaring step per
// bit below the top set bit, all through the single shared multiplier.
// One beat in flight: busy stays high until the result strobe, and the next
// beat can be taken in the strobe cycle; results cannot be stalled.
// Synchronous reset returns the sequencer to idle, no strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module iterative_integer_math_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [2:0]                           req_kind,
   input  wire logic signed [imu_pkg::DATA_WIDTH-1:0] req_operand_a,
   input  wire logic signed [imu_pkg::DATA_WIDTH-1:0] req_operand_b,
   input  wire logic signed [imu_pkg::DATA_WIDTH-1:0] req_operand_c,
   output logic                                      rsp_valid,
   output logic signed [imu_pkg::DATA_WIDTH-1:0]      rsp_value,
   output logic                                      rsp_ok
);

   import imu_pkg::*;

   localparam int W = DATA_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_FIX,
      ST_SQRT,
      ST_POW
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [W-1:0]        rsp_value_ff, rsp_value_in;

   // divide: remainder / quotient / divisor; square root: rest / root / trial bit
   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [W-1:0]        dv_ff, dv_in;
   logic                neg_ff, neg_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // power and multiply: accumulator, running base, remaining exponent
   logic [W-1:0]        acc_ff, acc_in;
   logic [W-1:0]        base_ff, base_in;
   logic [W-1:0]        exp_ff, exp_in;

   logic [W-1:0]        op_a, op_b, op_c;
   logic [W-1:0]        mag_a, mag_b;
   logic [W:0]          sub_lhs, sub_rhs, sub_diff;
   logic                sub_ge;
   logic [W-1:0]        mul_x, prod;

   assign op_a  = req_operand_a;
   assign op_b  = req_operand_b;
   assign op_c  = req_operand_c;
   assign mag_a = op_a[W-1] ? (~op_a + W'(1)) : op_a;
   assign mag_b = op_b[W-1] ? (~op_b + W'(1)) : op_b;

   // shared subtractor: divide trial or square root trial
   always_comb begin
      if (state_ff == ST_SQRT) begin
         sub_lhs = {1'b0, rem_ff};
         sub_rhs = {1'b0, quo_ff | dv_ff};
      end else begin
         sub_lhs = {rem_ff, quo_ff[W-1]};
         sub_rhs = {1'b0, dv_ff};
      end
   end
   assign sub_diff = sub_lhs - sub_rhs;
   assign sub_ge   = ~sub_diff[W];

   // shared multiplier: multiply into the accumulator on an odd exponent, else square
   assign mul_x = exp_ff[0] ? acc_ff : base_ff;
   assign prod  = mul_x * base_ff;

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dv_in        = dv_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_ok_in    = 1'b1;
               rsp_value_in = '0;
               case (kind_type'(req_kind))
                  KIND_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = op_a + op_b;
                  end
                  KIND_SUB: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = op_a - op_b;
                  end
                  KIND_SELECT: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = (op_a != '0) ? op_b : op_c;
                  end
                  KIND_MUL: begin
                     acc_in   = op_a;
                     base_in  = op_b;
                     exp_in   = W'(1);
                     state_in = ST_POW;
                  end
                  KIND_POWER: begin
                     if (op_b[W-1]) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b0;
                     end else begin
                        acc_in   = W'(1);
                        base_in  = op_a;
                        exp_in   = op_b;
                        state_in = ST_POW;
                     end
                  end
                  KIND_DIV: begin
                     if (op_b == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b0;
                     end else begin
                        rem_in   = '0;
                        quo_in   = mag_a;
                        dv_in    = mag_b;
                        neg_in   = op_a[W-1] ^ op_b[W-1];
                        step_in  = '0;
                        state_in = ST_DIV;
                     end
                  end
                  KIND_SQRT: begin
                     if (op_a[W-1]) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b0;
                     end else begin
                        rem_in   = op_a;
                        quo_in   = '0;
                        dv_in    = W'(1) << SQRT_TOP;
                        state_in = ST_SQRT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                  end
               endcase
            end
         end

         // one restoring step per quotient bit
         ST_DIV: begin
            if (sub_ge) begin
               rem_in = sub_diff[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = sub_lhs[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(W - 1)) begin
               state_in = ST_DIV_FIX;
            end
         end

         // apply the quotient sign
         ST_DIV_FIX: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = neg_ff ? (~quo_ff + W'(1)) : quo_ff;
            state_in     = ST_IDLE;
         end

         // one bit pair per cycle; root bits never overlap the trial bit
         ST_SQRT: begin
            if (sub_ge) begin
               rem_in = sub_diff[W-1:0];
               quo_in = (quo_ff >> 1) | dv_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            dv_in = dv_ff >> 2;
            if (dv_ff[0]) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sub_ge ? ((quo_ff >> 1) | dv_ff) : (quo_ff >> 1);
               state_in     = ST_IDLE;
            end
         end

         // square and multiply, one product per cycle
         ST_POW: begin
            if (exp_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               state_in     = ST_IDLE;
            end else if (exp_ff[0]) begin
               acc_in = prod;
               exp_in = {exp_ff[W-1:1], 1'b0};
            end else begin
               base_in = prod;
               exp_in  = exp_ff >> 1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state, datapath and the registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dv_ff        <= dv_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_value = rsp_value_ff;

endmodule : iterative_integer_math_unit

`default_nettype wire

### bench/tb_iterative_integer_math_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iterative_integer_math_unit
// Self-checking bench for the iterative integer math unit. A short table of
// corner operations runs first, then random operations with random gaps
// before each start, none within blocks sent back to back. Every accepted
// request is turned into an expected value and ok flag, either typed into
// the table or computed by a local model of each operation, and every
// response strobe is compared against the oldest pending expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_iterative_integer_math_unit;
   import imu_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int RANDOM_OPS = 500;
   localparam int DRAIN_CYCLES = 2 * W + 16;

   // kind code with no operation behind it
   localparam logic [2:0] KIND_UNUSED = 3'd7;

   typedef logic signed [W-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(W-1){1'b0}}};
   localparam word_type WORD_NEG1 = '1;

   typedef struct packed {
      logic [2:0] kind;
      word_type   a;
      word_type   b;
      word_type   c;
      logic       pinned;
      word_type   value;
      logic       ok;
   } op_row_type;

   typedef struct packed {
      logic [2:0] kind;
      word_type   value;
      logic       ok;
   } outcome_type;

   localparam int NUM_ROWS = 26;

   // corner operations; pinned rows carry their answer, the rest use the model
   localparam op_row_type CORNER_OPS [NUM_ROWS] = '{
      '{KIND_ADD,    WORD_MAX, 32'sd1,    32'sd0,   1'b1, WORD_MIN,   1'b1},
      '{KIND_ADD,    WORD_MIN, WORD_NEG1, 32'sd0,   1'b1, WORD_MAX,   1'b1},
      '{KIND_SUB,    WORD_MIN, 32'sd1,    32'sd0,   1'b1, WORD_MAX,   1'b1},
      '{KIND_SUB,    32'sd0,   WORD_MIN,  32'sd0,   1'b1, WORD_MIN,   1'b1},
      '{KIND_MUL,    WORD_MAX, WORD_MAX,  32'sd0,   1'b1, 32'sd1,     1'b1},
      '{KIND_MUL,    WORD_MIN, WORD_NEG1, 32'sd0,   1'b1, WORD_MIN,   1'b1},
      '{KIND_MUL,    -32'sd12345, 32'sd67891, 32'sd0, 1'b0, 32'sd0,   1'b0},
      '{KIND_DIV,    32'sd7,   32'sd0,    32'sd0,   1'b1, 32'sd0,     1'b0},
      '{KIND_DIV,    WORD_MIN, WORD_NEG1, 32'sd0,   1'b1, WORD_MIN,   1'b1},
      '{KIND_DIV,    -32'sd7,  32'sd2,    32'sd0,   1'b1, -32'sd3,    1'b1},
      '{KIND_DIV,    32'sd7,   -32'sd2,   32'sd0,   1'b1, -32'sd3,    1'b1},
      '{KIND_DIV,    WORD_MAX, 32'sd1,    32'sd0,   1'b1, WORD_MAX,   1'b1},
      '{KIND_DIV,    WORD_MIN, WORD_MAX,  32'sd0,   1'b1, WORD_NEG1,  1'b1},
      '{KIND_SELECT, 32'sd0,   32'sd5,    WORD_MIN, 1'b1, WORD_MIN,   1'b1},
      '{KIND_SELECT, WORD_MIN, WORD_MAX,  32'sd9,   1'b1, WORD_MAX,   1'b1},
      '{KIND_SQRT,   WORD_MAX, 32'sd0,    32'sd0,   1'b1, 32'sd46340, 1'b1},
      '{KIND_SQRT,   32'sd0,   32'sd0,    32'sd0,   1'b1, 32'sd0,     1'b1},
      '{KIND_SQRT,   WORD_NEG1, 32'sd0,   32'sd0,   1'b1, 32'sd0,     1'b0},
      '{KIND_SQRT,   WORD_MIN, 32'sd0,    32'sd0,   1'b1, 32'sd0,     1'b0},
      '{KIND_POWER,  32'sd0,   32'sd0,    32'sd0,   1'b1, 32'sd1,     1'b1},
      '{KIND_POWER,  32'sd2,   WORD_NEG1, 32'sd0,   1'b1, 32'sd0,     1'b0},
      '{KIND_POWER,  32'sd2,   32'sd31,   32'sd0,   1'b1, WORD_MIN,   1'b1},
      '{KIND_POWER,  32'sd2,   WORD_MAX,  32'sd0,   1'b1, 32'sd0,     1'b1},
      '{KIND_POWER,  WORD_NEG1, WORD_MAX, 32'sd0,   1'b1, WORD_NEG1,  1'b1},
      '{KIND_POWER,  32'sd3,   32'sd1000001, 32'sd0, 1'b0, 32'sd0,    1'b0},
      '{KIND_UNUSED, WORD_MAX, WORD_MAX,  WORD_MAX, 1'b1, 32'sd0,     1'b0}
   };

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_kind;
   word_type   req_operand_a;
   word_type   req_operand_b;
   word_type   req_operand_c;
   logic       rsp_valid;
   word_type   rsp_value;
   logic       rsp_ok;

   // answer attached to the beat currently offered
   logic       offer_pinned;
   word_type   offer_value;
   logic       offer_ok;

   outcome_type pending_outcomes [$];
   int          error_count;
   bit          no_idle;

   iterative_integer_math_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_operand_c (req_operand_c),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_ok        (rsp_ok)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // compute value and ok flag for one operation
   function automatic outcome_type compute_outcome(logic [2:0] kind, word_type a,
                                                   word_type b, word_type c);
      outcome_type  res;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] quot;
      logic [W-1:0] rem;
      logic [W-1:0] root;
      logic [W-1:0] trial;
      logic [W-1:0] acc;
      logic [W-1:0] base;
      logic [W-1:0] expo;
      res.kind  = kind;
      res.value = '0;
      res.ok    = 1'b1;
      case (kind)
         KIND_ADD:    res.value = a + b;
         KIND_SUB:    res.value = a - b;
         KIND_MUL:    res.value = a * b;
         KIND_DIV: begin
            if (b == 0) begin
               res.ok = 1'b0;
            end else begin
               mag_a = a[W-1] ? -a : a;
               mag_b = b[W-1] ? -b : b;
               quot  = mag_a / mag_b;
               res.value = (a[W-1] ^ b[W-1]) ? -quot : quot;
            end
         end
         KIND_SELECT: res.value = (a != 0) ? b : c;
         KIND_SQRT: begin
            if (a[W-1]) begin
               res.ok = 1'b0;
            end else begin
               // settle one root bit per bit pair, top down
               rem   = a;
               root  = '0;
               trial = 1;
               trial = trial << (W - 2);
               while (trial > rem)
                  trial = trial >> 2;
               while (trial != 0) begin
                  if (rem >= root + trial) begin
                     rem  = rem - (root + trial);
                     root = (root >> 1) + trial;
                  end else begin
                     root = root >> 1;
                  end
                  trial = trial >> 2;
               end
               res.value = root;
            end
         end
         KIND_POWER: begin
            if (b[W-1]) begin
               res.ok = 1'b0;
            end else begin
               // square and multiply, wrapping at the word width
               acc  = 1;
               base = a;
               expo = b;
               while (expo != 0) begin
                  if (expo[0])
                     acc = acc * base;
                  base = base * base;
                  expo = expo >> 1;
               end
               res.value = acc;
            end
         end
         default: res.ok = 1'b0;
      endcase
      return res;
   endfunction

   // draw an operand: full range, near zero, or an extreme
   function automatic word_type draw_word();
      word_type w;
      case ($urandom_range(0, 3))
         0, 1: w = $urandom;
         2:    w = int'($urandom_range(0, 32)) - 16;
         default: begin
            case ($urandom_range(0, 4))
               0:       w = WORD_MIN;
               1:       w = WORD_MAX;
               2:       w = '0;
               3:       w = WORD_NEG1;
               default: w = 1;
            endcase
         end
      endcase
      return w;
   endfunction

   // offer one beat after a random gap, none while no_idle is set, return at the edge that takes it
   task automatic send_op(op_row_type row);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= row.kind;
      req_operand_a <= row.a;
      req_operand_b <= row.b;
      req_operand_c <= row.c;
      offer_pinned  <= row.pinned;
      offer_value   <= row.value;
      offer_ok      <= row.ok;
      do
         @(posedge clock);
      while (busy);
   endtask

   // check strobed results, then record the beat taken at this edge
   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected result value=%0d ok=%0b", $time, rsp_value,
                        rsp_ok);
               error_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_value !== want.value) begin
                  $display("%0t: kind %0d value expected %0d actual %0d", $time,
                           want.kind, want.value, rsp_value);
                  error_count++;
               end
               if (rsp_ok !== want.ok) begin
                  $display("%0t: kind %0d ok expected %0b actual %0b", $time,
                           want.kind, want.ok, rsp_ok);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            if (offer_pinned) begin
               want.kind  = req_kind;
               want.value = offer_value;
               want.ok    = offer_ok;
            end else begin
               want = compute_outcome(req_kind, req_operand_a, req_operand_b,
                                      req_operand_c);
            end
            pending_outcomes.push_back(want);
         end
      end
   end

   initial begin
      op_row_type row;
      int         kind_draw;
      error_count   = 0;
      no_idle       = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      req_operand_c = '0;
      offer_pinned  = 1'b0;
      offer_value   = '0;
      offer_ok      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the corner table
      for (int i = 0; i < NUM_ROWS; i++)
         send_op(CORNER_OPS[i]);

      // random operations, every third block of 40 sent back to back
      for (int n = 0; n < RANDOM_OPS; n++) begin
         no_idle    = ((n / 40) % 3 == 1);
         row.pinned = 1'b0;
         row.value  = '0;
         row.ok     = 1'b0;
         kind_draw  = $urandom_range(0, 15);
         row.kind   = (kind_draw >= 14) ? KIND_UNUSED : 3'(kind_draw % 7);
         row.a      = draw_word();
         row.b      = draw_word();
         row.c      = draw_word();
         case (row.kind)
            KIND_DIV: begin
               case ($urandom_range(0, 9))
                  0: row.b = '0;
                  1: begin
                     row.b = WORD_NEG1;
                     if ($urandom_range(0, 1) == 0)
                        row.a = WORD_MIN;
                  end
                  default: ;
               endcase
            end
            KIND_SELECT: begin
               if ($urandom_range(0, 2) == 0)
                  row.a = '0;
            end
            KIND_SQRT: begin
               if ($urandom_range(0, 4) != 0)
                  row.a[W-1] = 1'b0;
            end
            KIND_POWER: begin
               if ($urandom_range(0, 3) != 0)
                  row.b = $urandom_range(0, 40);
            end
            default: ;
         endcase
         send_op(row);
      end
      start <= 1'b0;

      // drain outstanding results, then watch for stray strobes
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // stop a hung run
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/imu_pkg.sv
rtl/core/iterative_integer_math_unit.sv
bench/tb_iterative_integer_math_unit.sv
